// File: rtl/json_token_lexer_defines.svh
// ----------------------------------------------------------------------------
// json_token_lexer_defines
// assertion macros for the json token lexer
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_LEXER_DEFINES_SVH
`define JSON_TOKEN_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
`define JTL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define JTL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define JTL_ASSERT_NOW(label, ante, cons)
`define JTL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/jtl_pkg.sv
// ----------------------------------------------------------------------------
// jtl_pkg
// types, codes and tables shared by the json token lexer
// ----------------------------------------------------------------------------
package jtl_pkg;

	localparam int MaxRes = 4;

	localparam logic [1:0] KIND_CONTENT = 2'd0;
	localparam logic [1:0] KIND_TOKEN   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [3:0] TOK_LBRACE = 4'd0;
	localparam logic [3:0] TOK_RBRACE = 4'd1;
	localparam logic [3:0] TOK_LBRACK = 4'd2;
	localparam logic [3:0] TOK_RBRACK = 4'd3;
	localparam logic [3:0] TOK_COLON  = 4'd4;
	localparam logic [3:0] TOK_COMMA  = 4'd5;
	localparam logic [3:0] TOK_NULL   = 4'd6;
	localparam logic [3:0] TOK_NUMBER = 4'd9;
	localparam logic [3:0] TOK_STRING = 4'd10;
	localparam logic [3:0] TOK_END    = 4'd11;

	typedef enum logic [3:0] {
		M_IDLE, M_KW_NULL, M_KW_TRUE, M_KW_FALSE, M_N_MINUS, M_N_ZERO, M_N_INT,
		M_N_DOT, M_N_FRAC, M_N_EXP, M_N_EXPSIGN, M_N_EXPDIG, M_STR, M_STR_ESC,
		M_STR_HEX, M_ERROR
	} mode_t;

	typedef struct packed {
		mode_t        mode;
		logic [2:0]   kw_prog;
		logic [4:0]   shift;
		logic [20:0]  code;
		logic [15:0]  hi_sur;
		logic [15:0]  hex;
		logic [1:0]   hex_cnt;
		logic         str_ok;
	} lex_st_t;

	localparam lex_st_t LEX_RESET = '{mode: M_IDLE, kw_prog: 3'd0, shift: 5'd0,
		code: 21'd0, hi_sur: 16'd0, hex: 16'd0, hex_cnt: 2'd0, str_ok: 1'b1};

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] tok;
		logic [7:0] data;
	} res_t;

	typedef struct packed {
		res_t [MaxRes-1:0] r;
		logic [2:0]        n;
	} batch_t;

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		return (k == 2'd2) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] c;
		c = 8'h00;
		unique case (k)
			2'd0: c = (i == 3'd0) ? 8'h6e : (i == 3'd1) ? 8'h75 : 8'h6c;
			2'd1: c = (i == 3'd0) ? 8'h74 : (i == 3'd1) ? 8'h72 :
				(i == 3'd2) ? 8'h75 : 8'h65;
			default: c = (i == 3'd0) ? 8'h66 : (i == 3'd1) ? 8'h61 :
				(i == 3'd2) ? 8'h6c : (i == 3'd3) ? 8'h73 : 8'h65;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return {1'b0, b[3:0]};
		if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
			return {1'b0, b[3:0] + 4'd9};
		return 5'd16;
	endfunction

endpackage

// File: rtl/jtl_step.sv
// ----------------------------------------------------------------------------
// jtl_step
// next state and result words for one text byte
// ----------------------------------------------------------------------------
module jtl_step (
	input  jtl_pkg::lex_st_t cur,
	input  logic [7:0]       b,
	output jtl_pkg::lex_st_t nxt,
	output jtl_pkg::batch_t  res
);

	typedef struct packed {
		jtl_pkg::lex_st_t st;
		jtl_pkg::batch_t  bt;
	} work_t;

	function automatic work_t push(work_t w, logic [1:0] k, logic [3:0] t, logic [7:0] d);
		work_t o;
		o = w;
		if (o.bt.n < 3'd4) begin
			o.bt.r[o.bt.n[1:0]] = '{kind: k, tok: t, data: d};
			o.bt.n = o.bt.n + 3'd1;
		end
		return o;
	endfunction

	function automatic work_t fail(work_t w, logic [7:0] c);
		work_t o;
		o = push(w, jtl_pkg::KIND_ERROR, 4'd0, 8'd0);
		if (c == 8'd0) begin
			o = push(o, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_END, 8'd0);
			o.st = jtl_pkg::LEX_RESET;
		end else begin
			o.st.mode = jtl_pkg::M_ERROR;
		end
		return o;
	endfunction

	function automatic logic is_dig(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic work_t start_tok(work_t w, logic [7:0] c);
		work_t o;
		o = w;
		priority case (c)
			8'h20, 8'h09, 8'h0a, 8'h0d: o = w;
			8'h00: begin
				o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_END, 8'd0);
				o.st = jtl_pkg::LEX_RESET;
			end
			8'h7b: o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_LBRACE, 8'd0);
			8'h7d: o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_RBRACE, 8'd0);
			8'h5b: o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_LBRACK, 8'd0);
			8'h5d: o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_RBRACK, 8'd0);
			8'h3a: o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_COLON, 8'd0);
			8'h2c: o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_COMMA, 8'd0);
			8'h6e: begin o.st.mode = jtl_pkg::M_KW_NULL; o.st.kw_prog = 3'd1; end
			8'h74: begin o.st.mode = jtl_pkg::M_KW_TRUE; o.st.kw_prog = 3'd1; end
			8'h66: begin o.st.mode = jtl_pkg::M_KW_FALSE; o.st.kw_prog = 3'd1; end
			8'h2d: begin
				o = push(w, jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_NUMBER, c);
				o.st.mode = jtl_pkg::M_N_MINUS;
			end
			8'h22: begin
				o.st = jtl_pkg::LEX_RESET;
				o.st.mode = jtl_pkg::M_STR;
			end
			default: begin
				if (is_dig(c)) begin
					o = push(w, jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_NUMBER, c);
					o.st.mode = (c == 8'h30) ? jtl_pkg::M_N_ZERO : jtl_pkg::M_N_INT;
				end else begin
					o = fail(w, c);
				end
			end
		endcase
		return o;
	endfunction

	function automatic work_t num_acc(work_t w, logic [7:0] c, jtl_pkg::mode_t m);
		work_t o;
		o = push(w, jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_NUMBER, c);
		o.st.mode = m;
		return o;
	endfunction

	function automatic work_t end_num(work_t w, logic [7:0] c);
		work_t o;
		o = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_NUMBER, 8'd0);
		o.st.mode = jtl_pkg::M_IDLE;
		return start_tok(o, c);
	endfunction

	function automatic work_t put_s(work_t w, logic [7:0] d);
		return push(w, jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_STRING, d);
	endfunction

	function automatic work_t encode(work_t w, logic [20:0] cp);
		work_t o;
		if (cp <= 21'h7f) begin
			o = put_s(w, cp[7:0]);
		end else if (cp <= 21'h7ff) begin
			o = put_s(w, {3'b110, cp[10:6]});
			o = put_s(o, {2'b10, cp[5:0]});
		end else if (cp <= 21'hffff) begin
			o = put_s(w, {4'b1110, cp[15:12]});
			o = put_s(o, {2'b10, cp[11:6]});
			o = put_s(o, {2'b10, cp[5:0]});
		end else begin
			o = put_s(w, {5'b11110, cp[20:18]});
			o = put_s(o, {2'b10, cp[17:12]});
			o = put_s(o, {2'b10, cp[11:6]});
			o = put_s(o, {2'b10, cp[5:0]});
		end
		return o;
	endfunction

	function automatic work_t take_pt(work_t w, logic [20:0] cp);
		work_t o;
		o = w;
		if (o.st.shift != 5'd0) o.st.str_ok = 1'b0;
		if (cp >= 21'hd800 && cp < 21'hdc00) begin
			if (o.st.hi_sur != 16'd0) o.st.str_ok = 1'b0;
			else o.st.hi_sur = cp[15:0];
		end else if (cp >= 21'hdc00 && cp < 21'he000) begin
			if (o.st.hi_sur != 16'd0) begin
				o = encode(o, {1'b0, o.st.hi_sur[9:0], cp[9:0]} | 21'h10000);
				o.st.hi_sur = 16'd0;
			end else begin
				o.st.str_ok = 1'b0;
			end
		end else if (o.st.hi_sur != 16'd0) begin
			o.st.str_ok = 1'b0;
		end else begin
			o = encode(o, cp);
		end
		return o;
	endfunction

	function automatic work_t take_byte(work_t w, logic [7:0] c);
		work_t o;
		logic [4:0] sh;
		o = w;
		sh = w.st.shift - 5'd6;
		if (w.st.shift == 5'd0) begin
			if (c < 8'h80) o = put_s(w, c);
			else if (c < 8'hc0) o.st.str_ok = 1'b0;
			else if (c < 8'he0) begin
				o.st.code = {10'd0, c[4:0], 6'd0}; o.st.shift = 5'd6;
			end else if (c < 8'hf0) begin
				o.st.code = {5'd0, c[3:0], 12'd0}; o.st.shift = 5'd12;
			end else if (c < 8'hf8) begin
				o.st.code = {c[2:0], 18'd0}; o.st.shift = 5'd18;
			end else o.st.str_ok = 1'b0;
		end else begin
			if (c[7:6] != 2'b10) o.st.str_ok = 1'b0;
			o.st.shift = sh;
			o.st.code = w.st.code | ({15'd0, c[5:0]} << sh);
			if (sh == 5'd0) o = take_pt(o, o.st.code);
		end
		return o;
	endfunction

	always_comb begin
		work_t w;
		logic [1:0] k;
		logic [4:0] hv;
		logic [15:0] hx;
		w.st = cur;
		w.bt = '0;
		k = 2'(cur.mode - jtl_pkg::M_KW_NULL);
		hv = jtl_pkg::hex_val(b);
		hx = {cur.hex[11:0], hv[3:0]};
		unique case (cur.mode)
			jtl_pkg::M_IDLE: w = start_tok(w, b);
			jtl_pkg::M_KW_NULL, jtl_pkg::M_KW_TRUE, jtl_pkg::M_KW_FALSE: begin
				if (cur.kw_prog < jtl_pkg::kw_len(k) && b == jtl_pkg::kw_char(k, cur.kw_prog)) begin
					w.st.kw_prog = cur.kw_prog + 3'd1;
					if (w.st.kw_prog == jtl_pkg::kw_len(k)) begin
						w = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_NULL + {2'd0, k}, 8'd0);
						w.st.mode = jtl_pkg::M_IDLE;
						w.st.kw_prog = 3'd0;
					end
				end else begin
					w.st.kw_prog = 3'd0;
					w = fail(w, b);
				end
			end
			jtl_pkg::M_N_MINUS:
				if (is_dig(b))
					w = num_acc(w, b, (b == 8'h30) ? jtl_pkg::M_N_ZERO : jtl_pkg::M_N_INT);
				else w = fail(w, b);
			jtl_pkg::M_N_ZERO, jtl_pkg::M_N_INT: begin
				if (is_dig(b)) begin
					if (cur.mode == jtl_pkg::M_N_ZERO) w = fail(w, b);
					else w = num_acc(w, b, jtl_pkg::M_N_INT);
				end else if (b == 8'h2e) w = num_acc(w, b, jtl_pkg::M_N_DOT);
				else if (b == 8'h65 || b == 8'h45) w = num_acc(w, b, jtl_pkg::M_N_EXP);
				else w = end_num(w, b);
			end
			jtl_pkg::M_N_DOT:
				if (is_dig(b)) w = num_acc(w, b, jtl_pkg::M_N_FRAC);
				else w = fail(w, b);
			jtl_pkg::M_N_FRAC:
				if (is_dig(b)) w = num_acc(w, b, jtl_pkg::M_N_FRAC);
				else if (b == 8'h65 || b == 8'h45) w = num_acc(w, b, jtl_pkg::M_N_EXP);
				else w = end_num(w, b);
			jtl_pkg::M_N_EXP:
				if (b == 8'h2b || b == 8'h2d) w = num_acc(w, b, jtl_pkg::M_N_EXPSIGN);
				else if (is_dig(b)) w = num_acc(w, b, jtl_pkg::M_N_EXPDIG);
				else w = fail(w, b);
			jtl_pkg::M_N_EXPSIGN:
				if (is_dig(b)) w = num_acc(w, b, jtl_pkg::M_N_EXPDIG);
				else w = fail(w, b);
			jtl_pkg::M_N_EXPDIG:
				if (is_dig(b)) w = num_acc(w, b, jtl_pkg::M_N_EXPDIG);
				else w = end_num(w, b);
			jtl_pkg::M_STR: begin
				if (b < 8'h20) w = fail(w, b);
				else if (b == 8'h5c) w.st.mode = jtl_pkg::M_STR_ESC;
				else if (b == 8'h22) begin
					if (cur.str_ok && cur.shift == 5'd0 && cur.hi_sur == 16'd0)
						w = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_STRING, 8'd0);
					else
						w = push(w, jtl_pkg::KIND_ERROR, 4'd0, 8'd0);
					w.st = jtl_pkg::LEX_RESET;
				end else w = take_byte(w, b);
			end
			jtl_pkg::M_STR_ESC: begin
				w.st.mode = jtl_pkg::M_STR;
				priority case (b)
					8'h22, 8'h5c, 8'h2f: w = take_byte(w, b);
					8'h62: w = take_byte(w, 8'h08);
					8'h66: w = take_byte(w, 8'h0c);
					8'h6e: w = take_byte(w, 8'h0a);
					8'h72: w = take_byte(w, 8'h0d);
					8'h74: w = take_byte(w, 8'h09);
					8'h75: begin
						w.st.mode = jtl_pkg::M_STR_HEX;
						w.st.hex = 16'd0;
						w.st.hex_cnt = 2'd0;
					end
					default: w = fail(w, b);
				endcase
			end
			jtl_pkg::M_STR_HEX: begin
				if (hv[4]) w = fail(w, b);
				else begin
					w.st.hex = hx;
					if (cur.hex_cnt == 2'd3) begin
						w.st.hex_cnt = 2'd0;
						w.st.mode = jtl_pkg::M_STR;
						w = take_pt(w, {5'd0, hx});
					end else w.st.hex_cnt = cur.hex_cnt + 2'd1;
				end
			end
			default: begin
				if (b == 8'd0) begin
					w = push(w, jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_END, 8'd0);
					w.st = jtl_pkg::LEX_RESET;
				end else w.st.mode = jtl_pkg::M_ERROR;
			end
		endcase
		nxt = w.st;
		res = w.bt;
	end

endmodule

// File: rtl/jtl_outbuf.sv
// ----------------------------------------------------------------------------
// jtl_outbuf
// holds the result words of one byte and sends them out one per cycle while tready is high
// ----------------------------------------------------------------------------
module jtl_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  jtl_pkg::batch_t batch,
	input  logic            tready,
	output logic            tvalid,
	output jtl_pkg::res_t   word,
	output logic            tlast,
	output logic            free
);

	jtl_pkg::res_t [jtl_pkg::MaxRes-1:0] res_q;
	logic [2:0] rem_q;
	logic [1:0] pos_q;

	assign tvalid = rem_q != 3'd0;
	assign word   = res_q[pos_q];
	assign tlast  = rem_q == 3'd1;
	assign free   = rem_q == 3'd0 || (rem_q == 3'd1 && tready);

	always_ff @(posedge clk) begin
		if (load) res_q <= batch.r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			pos_q <= 2'd0;
		end else if (load) begin
			rem_q <= batch.n;
			pos_q <= 2'd0;
		end else if (tvalid && tready) begin
			rem_q <= rem_q - 3'd1;
			pos_q <= pos_q + 2'd1;
		end
	end

endmodule

// File: rtl/json_token_lexer.sv
// path: a taken byte is held in the input register, then its result words are loaded into the result buffer
// throughput: one byte per cycle while each byte gives at most one word and m_tready is high;
// a byte giving more words holds the result buffer until all of them are sent
// reset: arst_n clears the lexer state to idle between tokens and empties
// the input register and the result buffer
// ----------------------------------------------------------------------------
// json_token_lexer
// splits json text into tokens and decoded string and number bytes
// ----------------------------------------------------------------------------
`include "json_token_lexer_defines.svh"
module json_token_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // kind, token_type, data_byte
	output logic        m_tlast   // last
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	jtl_pkg::lex_st_t st_q;
	jtl_pkg::lex_st_t st_nxt;
	jtl_pkg::batch_t  batch;
	jtl_pkg::res_t    word;
	logic             free;
	logic             fire;

	assign fire     = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= jtl_pkg::LEX_RESET;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (fire) st_q <= st_nxt;
		end
	end

	jtl_step u_step (
		.cur (st_q),
		.b   (byte_s1),
		.nxt (st_nxt),
		.res (batch)
	);

	jtl_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.batch  (batch),
		.tready (m_tready),
		.tvalid (m_tvalid),
		.word   (word),
		.tlast  (m_tlast),
		.free   (free)
	);

	assign m_tdata = {2'b00, word.data, word.tok, word.kind};

	`JTL_ASSERT_NOW(a_load_when_free, fire, !m_tvalid || (m_tready && m_tlast))
	`JTL_ASSERT_NEXT(a_drain_done, m_tvalid && m_tready && m_tlast && !fire, !m_tvalid)
	`JTL_ASSERT_NOW(a_err_tok_zero, m_tvalid && word.kind == jtl_pkg::KIND_ERROR, word.tok == 4'd0)

endmodule

// File: dv/json_token_lexer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_token_lexer_test
// streams directed and random json text through the lexer, predicts every
// result word from a behavioral lexer model and compares them in order
// ----------------------------------------------------------------------------
module json_token_lexer_test;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] tok;
		logic [7:0] data;
		logic       last;
	} word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;

	json_token_lexer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	logic [7:0] text_q[$];
	word_t      expected_words[$];
	word_t      step_words[$];
	bit         failed;
	bit         hold_for_drain;
	bit         s_tready_seen;
	int         burst_left;
	int         gap_left;
	int         stall_phase;
	int         idle_cycles;
	int         n_items;

	// predictor state
	jtl_pkg::mode_t p_mode;
	int          p_kw;
	int          p_shift;
	logic [20:0] p_code;
	logic [15:0] p_hisur;
	logic [15:0] p_hex;
	int          p_hexcnt;
	bit          p_ok;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_word(logic [1:0] k, logic [3:0] t, logic [7:0] d);
		word_t w;
		w.kind = k;
		w.tok = t;
		w.data = d;
		w.last = 1'b0;
		if (step_words.size() < jtl_pkg::MaxRes)
			step_words.insert(step_words.size(), w);
	endfunction

	function automatic void clear_lexer();
		p_mode = jtl_pkg::M_IDLE;
		p_kw = 0;
		p_shift = 0;
		p_code = '0;
		p_hisur = '0;
		p_hex = '0;
		p_hexcnt = 0;
		p_ok = 1'b1;
	endfunction

	function automatic void raise_error(logic [7:0] b);
		push_word(jtl_pkg::KIND_ERROR, 4'd0, 8'd0);
		if (b == 8'd0) begin
			push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_END, 8'd0);
			clear_lexer();
		end else begin
			p_mode = jtl_pkg::M_ERROR;
		end
	endfunction

	function automatic bit is_num(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic void put_char(logic [7:0] b);
		push_word(jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_STRING, b);
	endfunction

	function automatic void encode_cp(logic [20:0] cp);
		if (cp <= 21'h7f) begin
			put_char(cp[7:0]);
		end else if (cp <= 21'h7ff) begin
			put_char(8'hc0 | cp[10:6]);
			put_char(8'h80 | cp[5:0]);
		end else if (cp <= 21'hffff) begin
			put_char(8'he0 | cp[15:12]);
			put_char(8'h80 | cp[11:6]);
			put_char(8'h80 | cp[5:0]);
		end else begin
			put_char(8'hf0 | cp[20:18]);
			put_char(8'h80 | cp[17:12]);
			put_char(8'h80 | cp[11:6]);
			put_char(8'h80 | cp[5:0]);
		end
	endfunction

	function automatic void take_cp(logic [20:0] cp);
		logic [20:0] full;
		if (p_shift != 0) p_ok = 1'b0;
		if (cp >= 21'hd800 && cp < 21'hdc00) begin
			if (p_hisur != 0) p_ok = 1'b0;
			else p_hisur = cp[15:0];
		end else if (cp >= 21'hdc00 && cp < 21'he000) begin
			if (p_hisur != 0) begin
				full = 21'h10000 | ((21'(p_hisur) - 21'hd800) << 10) | (cp - 21'hdc00);
				encode_cp(full);
				p_hisur = '0;
			end else begin
				p_ok = 1'b0;
			end
		end else if (p_hisur != 0) begin
			p_ok = 1'b0;
		end else begin
			encode_cp(cp);
		end
	endfunction

	function automatic void take_char(logic [7:0] b);
		if (p_shift == 0) begin
			if (b < 8'h80) put_char(b);
			else if (b < 8'hc0) p_ok = 1'b0;
			else if (b < 8'he0) begin p_code = 21'(b[4:0]) << 6; p_shift = 6; end
			else if (b < 8'hf0) begin p_code = 21'(b[3:0]) << 12; p_shift = 12; end
			else if (b < 8'hf8) begin p_code = 21'(b[2:0]) << 18; p_shift = 18; end
			else p_ok = 1'b0;
		end else begin
			if (b[7:6] != 2'b10) p_ok = 1'b0;
			p_shift -= 6;
			p_code = p_code | (21'(b[5:0]) << p_shift);
			if (p_shift == 0) take_cp(p_code);
		end
	endfunction

	function automatic void begin_token(logic [7:0] b);
		case (b)
			8'h20, 8'h09, 8'h0a, 8'h0d: ;
			8'h00: begin
				push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_END, 8'd0);
				clear_lexer();
			end
			"{": push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_LBRACE, 8'd0);
			"}": push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_RBRACE, 8'd0);
			"[": push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_LBRACK, 8'd0);
			"]": push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_RBRACK, 8'd0);
			":": push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_COLON, 8'd0);
			",": push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_COMMA, 8'd0);
			"n": begin p_mode = jtl_pkg::M_KW_NULL; p_kw = 1; end
			"t": begin p_mode = jtl_pkg::M_KW_TRUE; p_kw = 1; end
			"f": begin p_mode = jtl_pkg::M_KW_FALSE; p_kw = 1; end
			"-": begin
				push_word(jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_NUMBER, b);
				p_mode = jtl_pkg::M_N_MINUS;
			end
			"\"": begin clear_lexer(); p_mode = jtl_pkg::M_STR; end
			default: begin
				if (is_num(b)) begin
					push_word(jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_NUMBER, b);
					p_mode = (b == "0") ? jtl_pkg::M_N_ZERO : jtl_pkg::M_N_INT;
				end else begin
					raise_error(b);
				end
			end
		endcase
	endfunction

	function automatic void close_number(logic [7:0] b);
		push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_NUMBER, 8'd0);
		p_mode = jtl_pkg::M_IDLE;
		begin_token(b);
	endfunction

	function automatic void num_take(logic [7:0] b, jtl_pkg::mode_t nxt);
		push_word(jtl_pkg::KIND_CONTENT, jtl_pkg::TOK_NUMBER, b);
		p_mode = nxt;
	endfunction

	function automatic logic [7:0] kw_letter(int k, int i);
		string s;
		s = (k == 0) ? "null" : (k == 1) ? "true" : "false";
		return s[i];
	endfunction

	function automatic void lex_byte(logic [7:0] b);
		int k;
		int hv;
		word_t w;
		step_words.delete();
		case (p_mode)
			jtl_pkg::M_IDLE: begin_token(b);
			jtl_pkg::M_KW_NULL, jtl_pkg::M_KW_TRUE, jtl_pkg::M_KW_FALSE: begin
				k = int'(p_mode) - int'(jtl_pkg::M_KW_NULL);
				if (p_kw < ((k == 2) ? 5 : 4) && b == kw_letter(k, p_kw)) begin
					p_kw++;
					if (p_kw == ((k == 2) ? 5 : 4)) begin
						push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_NULL + 4'(k), 8'd0);
						p_mode = jtl_pkg::M_IDLE;
						p_kw = 0;
					end
				end else begin
					p_kw = 0;
					raise_error(b);
				end
			end
			jtl_pkg::M_N_MINUS:
				if (is_num(b)) num_take(b, b == "0" ? jtl_pkg::M_N_ZERO : jtl_pkg::M_N_INT);
				else raise_error(b);
			jtl_pkg::M_N_ZERO, jtl_pkg::M_N_INT: begin
				if (is_num(b)) begin
					if (p_mode == jtl_pkg::M_N_ZERO) raise_error(b);
					else num_take(b, jtl_pkg::M_N_INT);
				end else if (b == ".") num_take(b, jtl_pkg::M_N_DOT);
				else if (b == "e" || b == "E") num_take(b, jtl_pkg::M_N_EXP);
				else close_number(b);
			end
			jtl_pkg::M_N_DOT:
				if (is_num(b)) num_take(b, jtl_pkg::M_N_FRAC); else raise_error(b);
			jtl_pkg::M_N_FRAC: begin
				if (is_num(b)) num_take(b, jtl_pkg::M_N_FRAC);
				else if (b == "e" || b == "E") num_take(b, jtl_pkg::M_N_EXP);
				else close_number(b);
			end
			jtl_pkg::M_N_EXP: begin
				if (b == "+" || b == "-") num_take(b, jtl_pkg::M_N_EXPSIGN);
				else if (is_num(b)) num_take(b, jtl_pkg::M_N_EXPDIG);
				else raise_error(b);
			end
			jtl_pkg::M_N_EXPSIGN:
				if (is_num(b)) num_take(b, jtl_pkg::M_N_EXPDIG); else raise_error(b);
			jtl_pkg::M_N_EXPDIG:
				if (is_num(b)) num_take(b, jtl_pkg::M_N_EXPDIG); else close_number(b);
			jtl_pkg::M_STR: begin
				if (b < 8'h20) raise_error(b);
				else if (b == "\\") p_mode = jtl_pkg::M_STR_ESC;
				else if (b == "\"") begin
					if (p_shift != 0 || p_hisur != 0) p_ok = 1'b0;
					if (p_ok) push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_STRING, 8'd0);
					else push_word(jtl_pkg::KIND_ERROR, 4'd0, 8'd0);
					clear_lexer();
				end else take_char(b);
			end
			jtl_pkg::M_STR_ESC: begin
				p_mode = jtl_pkg::M_STR;
				case (b)
					"\"", "\\", "/": take_char(b);
					"b": take_char(8'h08);
					"f": take_char(8'h0c);
					"n": take_char(8'h0a);
					"r": take_char(8'h0d);
					"t": take_char(8'h09);
					"u": begin p_mode = jtl_pkg::M_STR_HEX; p_hex = '0; p_hexcnt = 0; end
					default: raise_error(b);
				endcase
			end
			jtl_pkg::M_STR_HEX: begin
				if (is_num(b)) hv = b - 8'h30;
				else if (b >= "a" && b <= "f") hv = b - "a" + 10;
				else if (b >= "A" && b <= "F") hv = b - "A" + 10;
				else hv = 16;
				if (hv > 15) raise_error(b);
				else begin
					p_hex = {p_hex[11:0], 4'(hv)};
					if (p_hexcnt == 3) begin
						p_hexcnt = 0;
						p_mode = jtl_pkg::M_STR;
						take_cp(21'(p_hex));
					end else p_hexcnt++;
				end
			end
			default: begin
				if (b == 8'd0) begin
					push_word(jtl_pkg::KIND_TOKEN, jtl_pkg::TOK_END, 8'd0);
					clear_lexer();
				end
			end
		endcase
		for (int i = 0; i < step_words.size(); i++) begin
			w = step_words[i];
			w.last = (i == step_words.size() - 1);
			expected_words.insert(expected_words.size(), w);
		end
	endfunction

	task automatic put_text(logic [7:0] b);
		text_q.insert(text_q.size(), b);
		n_items++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) put_text(s[i]);
	endtask

	task automatic add_end();
		put_text(8'h00);
	endtask

	task automatic add_random_doc();
		int n;
		n = $urandom_range(1, 2);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 11))
				0: add_text("{\"k\":[1,-0.5e+3,true,null]}");
				1: add_text(" false ,\t");
				2: begin
					put_text("-");
					repeat ($urandom_range(1, 4)) put_text(8'($urandom_range(48, 57)));
					put_text("E");
					put_text(8'($urandom_range(48, 57)));
					put_text(" ");
				end
				3: begin
					put_text("\"");
					repeat ($urandom_range(0, 4)) put_text(8'($urandom_range(32, 126)));
					put_text("\"");
				end
				4: begin
					put_text("\"");
					put_text(8'($urandom_range(8'hc2, 8'hf4)));
					repeat ($urandom_range(1, 3)) put_text(8'($urandom_range(128, 191)));
					put_text("\"");
				end
				5: add_text($sformatf("\"\\u%04x\\u%04X\"", $urandom_range(16'hd800, 16'hdbff),
					$urandom_range(16'hdc00, 16'hdfff)));
				6: add_text($sformatf("\"\\u%04x\\n\\/\"", $urandom_range(0, 16'hffff)));
				7: put_text(8'($urandom_range(1, 255)));
				8: add_text("[0.1e-2,12]");
				9: add_text(":");
				10: begin
					put_text("\"");
					put_text(8'($urandom_range(128, 255)));
					put_text(8'($urandom_range(0, 255)));
				end
				default: add_text("\"\\ud800x\\x");
			endcase
		end
		add_end();
	endtask

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready_seen) begin
				if (text_q.size() > 0 && !hold_for_drain && burst_left > 0 && gap_left == 0) begin
					s_tdata <= text_q.pop_front();
					burst_left <= burst_left - 1;
				end else begin
					s_tvalid <= 1'b0;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= $urandom_range(0, 5);
					end
				end
			end else if (!s_tvalid) begin
				if (gap_left > 0) gap_left <= gap_left - 1;
				else if (text_q.size() > 0 && !hold_for_drain) begin
					s_tvalid <= 1'b1;
					s_tdata <= text_q.pop_front();
					if (burst_left == 0) burst_left <= $urandom_range(1, 20);
				end
			end
		end
	end

	// monitor: accepts, prediction and checking at the rising edge
	always @(posedge clk) begin
		word_t got;
		word_t exp_w;
		s_tready_seen = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				s_tready_seen = 1'b1;
				lex_byte(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[1:0], m_tdata[5:2], m_tdata[13:6], m_tlast};
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, actual %h", $realtime, got);
					failed = 1'b1;
				end else begin
					exp_w = expected_words.pop_front();
					if (got !== exp_w) begin
						$display("%0t: mismatch, expected kind %0d tok %0d data %h last %0d,",
							$realtime, exp_w.kind, exp_w.tok, exp_w.data, exp_w.last);
						$display("  actual kind %0d tok %0d data %h last %0d",
							got.kind, got.tok, got.data, got.last);
						failed = 1'b1;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles > 2000) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver stall pattern
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase[8]) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
		end
	end

	initial begin
		failed = 1'b0;
		idle_cycles = 0;
		n_items = 0;
		hold_for_drain = 1'b0;
		arst_n = 1'b0;
		clear_lexer();
		add_text("{}[]:,null\ttrue false\r\n-0.5e+7 12E3 0x");
		add_end();
		add_text("\"\\\"\\/\\n\\u00e9\\ud83d\\ude00\xc3\xa9\xf0\x9f\x98\x80\"");
		add_end();
		add_text("\"\x80\xff\"");
		add_end();
		add_text("nulx");
		add_end();
		add_text("\"\\q");
		add_end();
		add_text("\"\\uZ");
		add_end();
		add_text("\"\x01");
		add_end();
		add_text("\"\xe2\x41\x82\"");
		add_end();
		add_text("\"\\ud800\"");
		add_end();
		add_text("1.");
		add_end();
		repeat (8) @(posedge clk);
		arst_n = 1'b1;
		wait (text_q.size() == 0 && !s_tvalid);
		@(posedge clk);
		wait (expected_words.size() == 0);
		hold_for_drain = 1'b1;
		repeat (6) @(posedge clk);
		hold_for_drain = 1'b0;
		while (n_items < 120) add_random_doc();
		wait (text_q.size() == 0 && !s_tvalid);
		wait (expected_words.size() == 0);
		repeat (20) @(posedge clk);
		if (!failed && expected_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
